// ===== rtl/rrtt_pkg.sv =====
// rrtt_pkg: shared types and codes for the round-robin task table
// no dependencies
package rrtt_pkg;

  localparam logic [2:0] K_ADD    = 3'd0;
  localparam logic [2:0] K_REMOVE = 3'd1;
  localparam logic [2:0] K_SCHED  = 3'd2;
  localparam logic [2:0] K_RAISE  = 3'd3;
  localparam logic [2:0] K_SETST  = 3'd4;
  localparam logic [2:0] K_FIND   = 3'd5;
  localparam logic [2:0] K_LIST   = 3'd6;
  localparam logic [2:0] K_UNDEF  = 3'd7;

  localparam logic [2:0] S_OK    = 3'd0;
  localparam logic [2:0] S_NF    = 3'd1;
  localparam logic [2:0] S_EMPTY = 3'd2;
  localparam logic [2:0] S_FULL  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  localparam logic [2:0] T_STARTING = 3'd0;
  localparam logic [2:0] T_READY    = 3'd1;
  localparam logic [2:0] T_RUNNING  = 3'd2;
  localparam logic [2:0] T_ZOMBIE   = 3'd4;

  localparam logic [31:0] SIG_TOP = 32'h8000_0000;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_CHK   = 9'b000000100,
    ST_WR1   = 9'b000001000,
    ST_WR2   = 9'b000010000,
    ST_WR3   = 9'b000100000,
    ST_OUT   = 9'b001000000,
    ST_LWAIT = 9'b010000000,
    ST_DEMRD = 9'b100000000
  } state_t;

endpackage

// ===== rtl/round_robin_task_table_unit.sv =====
// round_robin_task_table_unit: top level, command sequencer over one slot ram
// depends on rrtt_pkg and rrtt_ram
//
// one command word enters on the s_axis channel; results leave on m_axis.
// every command gives one result word except list and the undefined kind; list
// gives one word per task with tlast on the final one (or one status word if
// the table is empty) and the undefined kind gives none. the per-slot record
// (pid, parent, state, signals, links) sits in one ram with a registered read;
// used bits, head, current and count are flops. commands that walk the ring
// do one ram read and one check per visited slot, and list sends each word as
// it checks the slot.
// one command is in work at a time: s_axis_tready is high only while idle.
// a finished word waits in the output register while m_axis_tready is low;
// the next command may run meanwhile but holds its own word, and list holds
// its walk, until the register is free.
// reset clears the used bits and the scalar state at once; the ram needs no
// clearing pass since entries are written by add before they are read.
module round_robin_task_table_unit #(
  parameter int MAX_TASKS = 16,
  parameter int PID_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0], pid[18:3], parent_pid[34:19], signal[39:35], new_state[42:40]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], pid_out[18:3], fresh_start[19], switched[20], task_count[25:21]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int RW = 2 * PID_BITS + 3 + 32 + 2 * IW;

  typedef struct packed {
    logic [PID_BITS-1:0] pid;
    logic [PID_BITS-1:0] parent;
    logic [2:0]          tst;
    logic [31:0]         sigs;
    logic [IW-1:0]       nxt;
    logic [IW-1:0]       prv;
  } rec_t;

  rrtt_pkg::state_t state;
  rec_t             rd, wr_rec;
  logic             we;
  logic [IW-1:0]    addr;
  logic [RW-1:0]    rd_bits;

  rrtt_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_rec), .rdata(rd_bits)
  );
  assign rd = rd_bits;

  logic [MAX_TASKS-1:0] used;
  logic [IW-1:0]        head, cur, slot, free_slot, tgt, aux;
  logic                 cur_valid;
  logic [CW-1:0]        count, steps;
  logic [PID_BITS-1:0]  last_pid;
  logic [2:0]           kind, nst;
  logic [PID_BITS-1:0]  cpid, cppid;
  logic [4:0]           sig;
  logic [1:0]           phase;
  rec_t                 hold;

  logic [2:0]  o_status;
  logic [15:0] o_pid;
  logic        o_fresh, o_sw, o_last;
  logic [4:0]  o_count;

  always_comb begin
    free_slot = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--)
      if (!used[i]) free_slot = IW'(i);
  end

  logic [15:0] pid_ext;
  assign pid_ext = 16'(rd.pid);

  assign s_axis_tready = (state == rrtt_pkg::ST_IDLE);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    logic we_v;
    logic vld_v;
    we_v  = 1'b0;
    vld_v = m_axis_tvalid && !m_axis_tready;
    if (rst) begin
      state         <= rrtt_pkg::ST_IDLE;
      used          <= '0;
      head          <= '0;
      cur           <= '0;
      cur_valid     <= 1'b0;
      count         <= '0;
      last_pid      <= '0;
      we            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      unique case (state)
        rrtt_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind  <= s_axis_tdata[2:0];
            cpid  <= PID_BITS'(s_axis_tdata[18:3]);
            cppid <= PID_BITS'(s_axis_tdata[34:19]);
            sig   <= s_axis_tdata[39:35];
            nst   <= s_axis_tdata[42:40];
            steps <= '0;
            phase <= '0;
            o_fresh <= 1'b0; o_sw <= 1'b0; o_pid <= '0;
            o_last <= (count == '0) && (s_axis_tdata[2:0] == rrtt_pkg::K_LIST);
            if (s_axis_tdata[2:0] == rrtt_pkg::K_UNDEF) begin
              state <= rrtt_pkg::ST_IDLE;
            end else if (s_axis_tdata[2:0] == rrtt_pkg::K_ADD) begin
              if (count == CW'(MAX_TASKS)) begin
                o_status <= rrtt_pkg::S_FULL;
                state <= rrtt_pkg::ST_OUT;
              end else begin
                o_status <= rrtt_pkg::S_OK;
                slot  <= free_slot;
                addr  <= head;
                state <= rrtt_pkg::ST_RD;
              end
            end else if (count == '0) begin
              o_status <= rrtt_pkg::S_EMPTY;
              state    <= rrtt_pkg::ST_OUT;
            end else begin
              o_status <= rrtt_pkg::S_OK;
              slot  <= (s_axis_tdata[2:0] == rrtt_pkg::K_SCHED && cur_valid) ? cur : head;
              addr  <= (s_axis_tdata[2:0] == rrtt_pkg::K_SCHED && cur_valid) ? cur : head;
              state <= rrtt_pkg::ST_RD;
            end
          end
        end
        rrtt_pkg::ST_RD: state <= rrtt_pkg::ST_CHK;
        rrtt_pkg::ST_CHK: begin
          hold <= rd;
          case (kind)
            rrtt_pkg::K_ADD: begin
              // rd is the old head (if any)
              tgt <= rd.prv;
              aux <= head;
              state <= rrtt_pkg::ST_WR1;
            end
            rrtt_pkg::K_LIST: begin
              if (out_free) begin
                o_pid  <= pid_ext;
                o_last <= (steps + 1'b1 == count);
                vld_v = 1'b1;
                m_axis_tlast  <= (steps + 1'b1 == count);
                m_axis_tdata  <= {6'd0, o_count, 1'b0, 1'b0, pid_ext, rrtt_pkg::S_OK};
                if (steps + 1'b1 == count) begin
                  state <= rrtt_pkg::ST_IDLE;
                end else begin
                  steps <= steps + 1'b1;
                  slot <= rd.nxt; addr <= rd.nxt;
                  state <= rrtt_pkg::ST_RD;
                end
              end
            end
            default: begin
              logic hit;
              hit = 1'b0;
              case (kind)
                rrtt_pkg::K_SCHED: hit = (rd.tst == rrtt_pkg::T_READY) ||
                                         (rd.tst == rrtt_pkg::T_STARTING);
                rrtt_pkg::K_FIND:  hit = (rd.parent == cpid) &&
                                         (rd.tst == rrtt_pkg::T_ZOMBIE);
                default:           hit = (rd.pid == cpid);
              endcase
              if (hit) begin
                state <= rrtt_pkg::ST_WR1;
              end else if (steps + 1'b1 == count) begin
                o_status <= (kind == rrtt_pkg::K_SCHED) ? rrtt_pkg::S_OK : rrtt_pkg::S_NF;
                if (kind == rrtt_pkg::K_SCHED && cur_valid) begin
                  addr <= cur; phase <= 2'd1; state <= rrtt_pkg::ST_DEMRD;
                end else state <= rrtt_pkg::ST_OUT;
              end else begin
                steps <= steps + 1'b1;
                slot <= rd.nxt; addr <= rd.nxt;
                state <= rrtt_pkg::ST_RD;
              end
            end
          endcase
        end
        rrtt_pkg::ST_DEMRD: begin
          // phase 1: read address settling; phase 2: data valid
          if (phase == 2'd1) phase <= 2'd2;
          else begin
            if (kind == rrtt_pkg::K_SCHED && !o_sw) begin
              o_pid <= pid_ext;
              state <= rrtt_pkg::ST_OUT;
            end else begin
              // demote current running task to ready
              if (rd.tst == rrtt_pkg::T_RUNNING) begin
                wr_rec <= '{pid: rd.pid, parent: rd.parent, tst: rrtt_pkg::T_READY,
                            sigs: rd.sigs, nxt: rd.nxt, prv: rd.prv};
                we_v = 1'b1;
              end
              state <= rrtt_pkg::ST_WR3;
            end
          end
        end
        rrtt_pkg::ST_WR1: begin
          case (kind) inside
            rrtt_pkg::K_ADD: begin
              if (count == '0) begin
                wr_rec <= '{pid: last_pid + 1'b1, parent: cppid, tst: rrtt_pkg::T_STARTING,
                            sigs: '0, nxt: slot, prv: slot};
                addr <= slot; we_v = 1'b1;
                state <= rrtt_pkg::ST_WR3;
              end else begin
                // old head: prev -> new slot
                wr_rec <= '{pid: hold.pid, parent: hold.parent, tst: hold.tst,
                            sigs: hold.sigs, nxt: (tgt == aux) ? slot : hold.nxt,
                            prv: slot};
                addr <= aux; we_v = 1'b1;
                state <= rrtt_pkg::ST_WR2;
                phase <= 2'd0;
              end
            end
            rrtt_pkg::K_REMOVE: begin
              if (count == CW'(1)) begin
                o_status <= rrtt_pkg::S_LAST; o_pid <= 16'(cpid);
                state <= rrtt_pkg::ST_OUT;
              end else begin
                tgt <= hold.prv; aux <= hold.nxt;
                addr <= hold.prv; phase <= 2'd0;
                state <= rrtt_pkg::ST_WR2;
              end
            end
            rrtt_pkg::K_RAISE, rrtt_pkg::K_SETST: begin
              wr_rec <= '{pid: hold.pid, parent: hold.parent,
                          tst: (kind == rrtt_pkg::K_RAISE) ? rrtt_pkg::T_READY : nst,
                          sigs: (kind == rrtt_pkg::K_RAISE)
                                ? (hold.sigs | (rrtt_pkg::SIG_TOP >> sig))
                                : hold.sigs,
                          nxt: hold.nxt, prv: hold.prv};
              addr <= slot; we_v = 1'b1;
              o_pid <= 16'(cpid);
              state <= rrtt_pkg::ST_OUT;
            end
            rrtt_pkg::K_FIND: begin
              o_pid <= 16'(hold.pid);
              state <= rrtt_pkg::ST_OUT;
            end
            default: begin
              // schedule hit
              o_sw <= 1'b1;
              o_fresh <= (hold.tst == rrtt_pkg::T_STARTING);
              o_pid <= 16'(hold.pid);
              if (cur_valid) begin
                addr <= cur; phase <= 2'd1; state <= rrtt_pkg::ST_DEMRD;
              end else state <= rrtt_pkg::ST_WR3;
            end
          endcase
        end
        rrtt_pkg::ST_WR2: begin
          if (kind == rrtt_pkg::K_ADD) begin
            // old tail: next -> new slot (when distinct from head), then new slot
            if (phase == 2'd0) begin
              addr <= tgt; phase <= 2'd1;
            end else if (phase == 2'd1) begin
              phase <= 2'd2;
            end else begin
              if (tgt != aux) begin
                wr_rec <= '{pid: rd.pid, parent: rd.parent, tst: rd.tst,
                            sigs: rd.sigs, nxt: slot, prv: rd.prv};
                addr <= tgt; we_v = 1'b1;
              end
              state <= rrtt_pkg::ST_WR3;
            end
          end else begin
            // remove: p.next = nx, then nx.prev = p
            if (phase == 2'd0) phase <= 2'd1;
            else if (phase == 2'd1) begin
              wr_rec <= '{pid: rd.pid, parent: rd.parent, tst: rd.tst,
                          sigs: rd.sigs, nxt: aux, prv: (tgt == aux) ? tgt : rd.prv};
              addr <= tgt; we_v = 1'b1;
              phase <= 2'd2;
            end else if (phase == 2'd2) begin
              addr <= aux; phase <= 2'd3;
            end else begin
              phase <= 2'd0;
              if (tgt != aux) begin
                state <= rrtt_pkg::ST_WR3;
              end else state <= rrtt_pkg::ST_WR3;
            end
          end
        end
        rrtt_pkg::ST_WR3: begin
          if (kind == rrtt_pkg::K_ADD) begin
            if (count != '0) begin
              wr_rec <= '{pid: last_pid + 1'b1, parent: cppid, tst: rrtt_pkg::T_STARTING,
                          sigs: '0, nxt: aux, prv: tgt};
              addr <= slot; we_v = 1'b1;
            end
            head <= slot;
            used[slot] <= 1'b1;
            last_pid <= last_pid + 1'b1;
            o_pid <= 16'(last_pid + 1'b1);
            count <= count + 1'b1;
            state <= rrtt_pkg::ST_OUT;
          end else if (kind == rrtt_pkg::K_REMOVE) begin
            if (phase == 2'd0) phase <= 2'd1;
            else begin
              if (tgt != aux) begin
                wr_rec <= '{pid: rd.pid, parent: rd.parent, tst: rd.tst,
                            sigs: rd.sigs, nxt: rd.nxt, prv: tgt};
                addr <= aux; we_v = 1'b1;
              end
              if (head == slot) head <= aux;
              if (cur_valid && cur == slot) cur_valid <= 1'b0;
              used[slot] <= 1'b0;
              count <= count - 1'b1;
              o_pid <= 16'(cpid);
              state <= rrtt_pkg::ST_OUT;
            end
          end else begin
            // schedule: mark chosen slot running (after any demotion)
            wr_rec <= '{pid: hold.pid, parent: hold.parent, tst: rrtt_pkg::T_RUNNING,
                        sigs: hold.sigs, nxt: hold.nxt, prv: hold.prv};
            addr <= slot; we_v = 1'b1;
            cur <= slot; cur_valid <= 1'b1;
            state <= rrtt_pkg::ST_OUT;
          end
        end
        rrtt_pkg::ST_OUT: begin
          if (out_free) begin
            vld_v = 1'b1;
            m_axis_tlast  <= o_last;
            m_axis_tdata  <= {6'd0, o_count, o_sw, o_fresh, o_pid, o_status};
            state <= rrtt_pkg::ST_IDLE;
          end
        end
        default: state <= rrtt_pkg::ST_IDLE;
      endcase
      we            <= we_v;
      m_axis_tvalid <= vld_v;
    end
  end

  assign o_count = 5'(count);

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS)) else $error("task count above table size");
  assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count)) else $error("used bits disagree with count");
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == rrtt_pkg::ST_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> used[cur]) else $error("current task not in table");
endmodule

// ===== rtl/rrtt_ram.sv =====
// rrtt_ram: generic single-port ram with registered read
// no dependencies
module rrtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== tb/round_robin_task_table_unit_test.sv =====
// round_robin_task_table_unit_test: self-checking bench for the task table unit
// keeps a behavioral copy of the slot ring, drives random command words
// depends on rrtt_pkg and round_robin_task_table_unit
`timescale 1ns / 100ps

module round_robin_task_table_unit_test;

  localparam int NSLOT = 16;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] pid;
    logic [15:0] parent_pid;
    logic [4:0]  signal;
    logic [2:0]  new_state;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pid_out;
    logic        fresh_start;
    logic        switched;
    logic [4:0]  task_count;
    logic        last;
  } res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  round_robin_task_table_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial forever #4 clk = ~clk;

  // table copy
  bit          t_used [NSLOT];
  logic [15:0] t_pid [NSLOT];
  logic [15:0] t_parent [NSLOT];
  logic [2:0]  t_state [NSLOT];
  logic [31:0] t_sigs [NSLOT];
  int          t_next [NSLOT];
  int          t_prev [NSLOT];
  int          head, cur, ntasks;
  bit          cur_ok;
  logic [15:0] last_pid;

  cmd_t cmd_q[$];
  res_t result_q[$];
  int   errors = 0, results_seen = 0, cmds_sent = 0;
  bit   hold_sender = 0;
  int   idle_cycles = 0;

  function automatic res_t mk(logic [2:0] st, logic [15:0] p, bit fr, bit sw, bit lst);
    res_t r;
    r.status = st; r.pid_out = p; r.fresh_start = fr; r.switched = sw;
    r.task_count = ntasks[4:0]; r.last = lst;
    return r;
  endfunction

  function automatic int slot_of(logic [15:0] p);
    int s;
    s = head;
    for (int n = 0; n < ntasks; n++) begin
      if (t_pid[s] == p) return s;
      s = t_next[s];
    end
    return -1;
  endfunction

  function automatic void predict_table(cmd_t c);
    int s, f, h, pv, nx;
    case (c.kind)
      rrtt_pkg::K_ADD: begin
        if (ntasks >= NSLOT) begin
          result_q.push_back(mk(rrtt_pkg::S_FULL, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        s = 0;
        while (t_used[s]) s++;
        if (ntasks == 0) begin
          t_next[s] = s; t_prev[s] = s;
        end else begin
          h = head; pv = t_prev[h];
          t_next[pv] = s; t_next[s] = h; t_prev[s] = pv; t_prev[h] = s;
        end
        head = s; t_used[s] = 1'b1; t_state[s] = rrtt_pkg::T_STARTING;
        t_parent[s] = c.parent_pid; t_sigs[s] = '0;
        last_pid = last_pid + 16'd1; t_pid[s] = last_pid;
        ntasks++;
        result_q.push_back(mk(rrtt_pkg::S_OK, last_pid, 1'b0, 1'b0, 1'b0));
      end
      rrtt_pkg::K_REMOVE: begin
        if (ntasks == 0) begin
          result_q.push_back(mk(rrtt_pkg::S_EMPTY, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        f = slot_of(c.pid);
        if (f < 0) begin
          result_q.push_back(mk(rrtt_pkg::S_NF, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        if (ntasks == 1) begin
          result_q.push_back(mk(rrtt_pkg::S_LAST, c.pid, 1'b0, 1'b0, 1'b0));
          return;
        end
        pv = t_prev[f]; nx = t_next[f];
        t_next[pv] = nx; t_prev[nx] = pv;
        if (head == f) head = nx;
        if (cur_ok && cur == f) cur_ok = 1'b0;
        t_used[f] = 1'b0; ntasks--;
        result_q.push_back(mk(rrtt_pkg::S_OK, c.pid, 1'b0, 1'b0, 1'b0));
      end
      rrtt_pkg::K_SCHED: begin
        if (ntasks == 0) begin
          result_q.push_back(mk(rrtt_pkg::S_EMPTY, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        s = cur_ok ? cur : head;
        for (int n = 0; n < ntasks; n++) begin
          if (t_state[s] == rrtt_pkg::T_READY || t_state[s] == rrtt_pkg::T_STARTING) begin
            bit fr;
            fr = (t_state[s] == rrtt_pkg::T_STARTING);
            if (cur_ok && t_state[cur] == rrtt_pkg::T_RUNNING)
              t_state[cur] = rrtt_pkg::T_READY;
            cur = s; cur_ok = 1'b1; t_state[s] = rrtt_pkg::T_RUNNING;
            result_q.push_back(mk(rrtt_pkg::S_OK, t_pid[s], fr, 1'b1, 1'b0));
            return;
          end
          s = t_next[s];
        end
        result_q.push_back(mk(rrtt_pkg::S_OK, cur_ok ? t_pid[cur] : 16'd0,
                              1'b0, 1'b0, 1'b0));
      end
      rrtt_pkg::K_RAISE, rrtt_pkg::K_SETST: begin
        if (ntasks == 0) begin
          result_q.push_back(mk(rrtt_pkg::S_EMPTY, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        f = slot_of(c.pid);
        if (f < 0) begin
          result_q.push_back(mk(rrtt_pkg::S_NF, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        if (c.kind == rrtt_pkg::K_RAISE) begin
          t_sigs[f] |= rrtt_pkg::SIG_TOP >> c.signal;
          t_state[f] = rrtt_pkg::T_READY;
        end else t_state[f] = c.new_state;
        result_q.push_back(mk(rrtt_pkg::S_OK, c.pid, 1'b0, 1'b0, 1'b0));
      end
      rrtt_pkg::K_FIND: begin
        if (ntasks == 0) begin
          result_q.push_back(mk(rrtt_pkg::S_EMPTY, '0, 1'b0, 1'b0, 1'b0));
          return;
        end
        s = head;
        for (int n = 0; n < ntasks; n++) begin
          if (t_parent[s] == c.pid && t_state[s] == rrtt_pkg::T_ZOMBIE) begin
            result_q.push_back(mk(rrtt_pkg::S_OK, t_pid[s], 1'b0, 1'b0, 1'b0));
            return;
          end
          s = t_next[s];
        end
        result_q.push_back(mk(rrtt_pkg::S_NF, '0, 1'b0, 1'b0, 1'b0));
      end
      rrtt_pkg::K_LIST: begin
        if (ntasks == 0) begin
          result_q.push_back(mk(rrtt_pkg::S_EMPTY, '0, 1'b0, 1'b0, 1'b1));
          return;
        end
        s = head;
        for (int n = 0; n < ntasks; n++) begin
          result_q.push_back(mk(rrtt_pkg::S_OK, t_pid[s], 1'b0, 1'b0, n + 1 == ntasks));
          s = t_next[s];
        end
      end
      default: ;
    endcase
  endfunction

  // pick an existing pid most of the time
  function automatic logic [15:0] some_pid();
    int s;
    if (ntasks > 0 && $urandom_range(0, 9) < 8) begin
      s = head;
      repeat ($urandom_range(0, ntasks - 1)) s = t_next[s];
      return t_pid[s];
    end
    return $urandom_range(0, 15) == 0 ? 16'hffff : 16'($urandom);
  endfunction

  // sender
  int   send_wait = 0;
  cmd_t cur_cmd;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_table(cur_cmd);
        cmds_sent++;
        send_wait = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) send_wait = 0;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (hold_sender && (result_q.size() != 0 || cmd_q.size() == 0)) begin
        s_axis_tvalid <= 0;
      end else if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 0;
      end else if (cmd_q.size() != 0) begin
        cur_cmd = cmd_q.pop_front();
        s_axis_tdata <= {5'd0, cur_cmd.new_state, cur_cmd.signal, cur_cmd.parent_pid,
                         cur_cmd.pid, cur_cmd.kind};
        s_axis_tvalid <= 1;
      end else s_axis_tvalid <= 0;
    end
  end

  // result monitor
  int recv_wait = 0;
  res_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.pid_out = m_axis_tdata[18:3];
        got.fresh_start = m_axis_tdata[19];
        got.switched = m_axis_tdata[20];
        got.task_count = m_axis_tdata[25:21];
        got.last = m_axis_tlast;
        results_seen++;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %p", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        recv_wait = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 0;
      end else m_axis_tready <= 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired");
        $display("[round_robin_task_table_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic cmd_t rnd_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.parent_pid = 16'($urandom);
    c.signal = 5'($urandom);
    c.new_state = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4));
    if (r < 22) c.kind = rrtt_pkg::K_ADD;
    else if (r < 34) c.kind = rrtt_pkg::K_REMOVE;
    else if (r < 56) c.kind = rrtt_pkg::K_SCHED;
    else if (r < 68) c.kind = rrtt_pkg::K_RAISE;
    else if (r < 82) c.kind = rrtt_pkg::K_SETST;
    else if (r < 92) c.kind = rrtt_pkg::K_FIND;
    else c.kind = rrtt_pkg::K_LIST;
    c.pid = some_pid();
    // find uses a parent id; mostly a known one
    if (c.kind == rrtt_pkg::K_FIND && $urandom_range(0, 3) != 0)
      c.pid = 16'($urandom_range(0, 3));
    if (c.kind == rrtt_pkg::K_ADD)
      c.parent_pid = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    return c;
  endfunction

  function automatic cmd_t mkc(logic [2:0] k, logic [15:0] p, logic [15:0] pp,
                               logic [4:0] sg, logic [2:0] ns);
    cmd_t c;
    c.kind = k; c.pid = p; c.parent_pid = pp; c.signal = sg; c.new_state = ns;
    return c;
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    // empty table on every command, then build and exercise a small ring
    cmd_q.push_back(mkc(rrtt_pkg::K_REMOVE, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SCHED, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_RAISE, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SETST, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_FIND, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_LIST, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_UNDEF, 16'hffff, 16'hffff, 5'd31, 3'd7));
    cmd_q.push_back(mkc(rrtt_pkg::K_ADD, '0, 16'hffff, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_REMOVE, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_ADD, '0, 16'd1, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_ADD, '0, 16'd1, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SCHED, '0, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SCHED, '0, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_RAISE, 16'd2, '0, 5'd0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_RAISE, 16'd3, '0, 5'd31, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SETST, 16'd2, '0, '0, rrtt_pkg::T_ZOMBIE));
    cmd_q.push_back(mkc(rrtt_pkg::K_SETST, 16'd3, '0, '0, 3'd7));
    cmd_q.push_back(mkc(rrtt_pkg::K_FIND, 16'd1, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_FIND, 16'hffff, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_SCHED, '0, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_REMOVE, 16'hffff, '0, '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_LIST, '0, '0, '0, '0));
    hold_sender = 1;
    drain();
    hold_sender = 0;
    // fill to full and past it
    for (int i = 0; i < 17; i++)
      cmd_q.push_back(mkc(rrtt_pkg::K_ADD, '0, 16'($urandom), '0, '0));
    cmd_q.push_back(mkc(rrtt_pkg::K_LIST, '0, '0, '0, '0));
    drain();
    for (int i = 0; i < 120; i++) begin
      cmd_q.push_back(rnd_cmd());
      while (cmd_q.size() != 0) @(negedge clk);
      if (i == 60) begin
        hold_sender = 1;
        drain();
        hold_sender = 0;
      end
    end
    drain();
    $display("sent %0d command words, checked %0d result words", cmds_sent, results_seen);
    if (errors == 0 && result_q.size() == 0) begin
      $display("[round_robin_task_table_unit] OK");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, result_q.size());
      $display("[round_robin_task_table_unit] ERROR");
    end
    $finish;
  end
endmodule
